@@ src/tcpa_pkg.sv @@
package tcpa_pkg;

  localparam int unsigned MaxSlots   = 16;
  localparam int unsigned MaxWaiters = 255;
  localparam int unsigned MaxServed  = 255;

  localparam int unsigned SlotW   = 5;
  localparam int unsigned WaitW   = 8;
  localparam int unsigned ServedW = 8;
  localparam int unsigned ThreshW = 8;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned NumCls  = 2;

  localparam logic [SlotW-1:0]   SlotMax   = SlotW'(MaxSlots);
  localparam logic [WaitW-1:0]   WaitMax   = WaitW'(MaxWaiters);
  localparam logic [ServedW-1:0] ServedMax = ServedW'(MaxServed);

  typedef enum logic {
    ModeArrive = 1'b0,
    ModeDepart = 1'b1
  } mode_e;

  typedef enum logic {
    CfgNumSlots  = 1'b0,
    CfgSwitchThr = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic mode;
    logic req_class;
  } evt_t;

  typedef struct packed {
    logic             grant_class;
    logic [SlotW-1:0] grant_count;
    logic             phase;
    logic [SlotW-1:0] occupancy;
    logic [WaitW-1:0] waiting_zero;
    logic [WaitW-1:0] waiting_one;
    logic             error;
  } res_t;

  typedef struct packed {
    logic                          phase;
    logic [NumCls-1:0][WaitW-1:0]  waiters;
    logic [ServedW-1:0]            served;
    logic [SlotW-1:0]              slots;
  } state_t;

  typedef struct packed {
    logic [SlotW-1:0]   num_slots;
    logic [ThreshW-1:0] switch_thr;
  } cfg_t;

endpackage

@@ src/tcpa_stream_if.sv @@
interface tcpa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/two_class_phase_admission_arbiter.sv @@
// An accepted event is registered in evt_q, evaluated combinationally by tcpa_step, and its result
// is loaded into the output register res_q as soon as that register is empty or being read.
// One event per cycle unless the result side stalls; the state updates in a single pass per event.
// Reset (rst_ni low, asynchronous): phase goes to class 0, all counters clear,
// num_slots returns to 4 and switch_threshold to 8, and both pipeline stages empty.
module two_class_phase_admission_arbiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tcpa_pkg::CfgW-1:0]     cfg_data_i,
  tcpa_stream_if.sink                   evt_i,
  tcpa_stream_if.source                 res_o
);

  tcpa_pkg::cfg_t   cfg_q;
  tcpa_pkg::state_t st_q;
  tcpa_pkg::state_t st_d;
  tcpa_pkg::evt_t   evt_q;
  logic             evt_vld_q;
  tcpa_pkg::res_t   res_d;
  tcpa_pkg::res_t   res_q;
  logic             res_vld_q;
  logic             res_free;
  logic             evt_adv;

  assign res_free    = !res_vld_q || res_o.ready;
  assign evt_adv     = evt_vld_q && res_free;
  assign evt_i.ready = !evt_vld_q || res_free;

  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_slots  <= tcpa_pkg::SlotW'(4);
      cfg_q.switch_thr <= tcpa_pkg::ThreshW'(8);
    end else if (cfg_we_i) begin
      unique case (tcpa_pkg::cfg_idx_e'(cfg_idx_i))
        tcpa_pkg::CfgNumSlots:  cfg_q.num_slots  <= cfg_data_i[tcpa_pkg::SlotW-1:0];
        tcpa_pkg::CfgSwitchThr: cfg_q.switch_thr <= cfg_data_i[tcpa_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  tcpa_step u_step (
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .evt_i (evt_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (evt_i.ready) begin
        evt_vld_q <= evt_i.valid;
      end
      if (evt_adv) begin
        st_q      <= st_d;
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      evt_q <= evt_i.payload;
    end
    if (evt_adv) begin
      res_q <= res_d;
    end
  end

endmodule

@@ src/tcpa_step.sv @@
module tcpa_step (
  input  tcpa_pkg::state_t st_i,
  input  tcpa_pkg::cfg_t   cfg_i,
  input  tcpa_pkg::evt_t   evt_i,
  output tcpa_pkg::state_t st_o,
  output tcpa_pkg::res_t   res_o
);

  logic [tcpa_pkg::SlotW-1:0]   lim;
  logic                         cls;
  logic                         oth;
  logic [tcpa_pkg::WaitW-1:0]   w_cls;
  logic [tcpa_pkg::WaitW-1:0]   w_oth;
  logic [tcpa_pkg::WaitW-1:0]   w_inc;
  logic                         w_sat;
  logic                         below_arr;
  logic [tcpa_pkg::SlotW-1:0]   s_dep;
  logic [tcpa_pkg::ServedW-1:0] sv_dep;
  logic                         below_dep;
  logic                         arr_enter;
  logic                         arr_switch;
  logic                         dep_enter;
  logic                         dep_switch;
  logic [tcpa_pkg::SlotW-1:0]   batch;
  logic                         gcls;
  logic [tcpa_pkg::SlotW-1:0]   gcnt;
  logic                         err;

  // Effective slot limit: zero acts as one, anything above the pool size is clipped.
  always_comb begin
    lim = cfg_i.num_slots;
    if (lim == '0) begin
      lim = tcpa_pkg::SlotW'(1);
    end else if (lim > tcpa_pkg::SlotMax) begin
      lim = tcpa_pkg::SlotMax;
    end
  end

  assign cls    = evt_i.req_class;
  assign oth    = ~evt_i.req_class;
  assign w_cls  = st_i.waiters[cls];
  assign w_oth  = st_i.waiters[oth];
  assign w_sat  = (w_cls >= tcpa_pkg::WaitMax);
  assign w_inc  = w_sat ? tcpa_pkg::WaitMax : w_cls + tcpa_pkg::WaitW'(1);

  assign below_arr = ({1'b0, 3'b000, st_i.slots} + {1'b0, st_i.served})
                     < {1'b0, cfg_i.switch_thr};

  // An arrival is admitted at once only if it can join its phase or take over an empty pool.
  assign arr_enter  = (st_i.phase == cls) && (st_i.slots < lim) &&
                      (below_arr || (w_oth == '0));
  assign arr_switch = (st_i.phase != cls) && (st_i.slots == '0) &&
                      (!below_arr || (w_oth == '0));

  assign s_dep  = st_i.slots - tcpa_pkg::SlotW'(1);
  assign sv_dep = (st_i.served == tcpa_pkg::ServedMax) ? tcpa_pkg::ServedMax
                                                       : st_i.served + tcpa_pkg::ServedW'(1);
  assign below_dep = ({1'b0, 3'b000, s_dep} + {1'b0, sv_dep})
                     < {1'b0, cfg_i.switch_thr};

  assign dep_enter  = (st_i.phase == cls) && (w_cls != '0) && (s_dep < lim) &&
                      (below_dep || (w_oth == '0));
  assign dep_switch = (st_i.phase == cls) && (s_dep == '0) && (w_oth != '0) &&
                      (!below_dep || (w_cls == '0));

  assign batch = (w_oth < {3'b000, lim}) ? tcpa_pkg::SlotW'(w_oth) : lim;

  always_comb begin
    st_o = st_i;
    gcls = 1'b0;
    gcnt = '0;
    err  = 1'b0;
    if (evt_i.mode == tcpa_pkg::ModeArrive) begin
      err = w_sat;
      st_o.waiters[cls] = w_inc;
      if (arr_enter || arr_switch) begin
        if (st_i.phase != cls) begin
          st_o.phase  = cls;
          st_o.served = '0;
        end
        st_o.waiters[cls] = w_inc - tcpa_pkg::WaitW'(1);
        st_o.slots        = st_i.slots + tcpa_pkg::SlotW'(1);
        gcls = cls;
        gcnt = tcpa_pkg::SlotW'(1);
      end
    end else if (st_i.slots == '0) begin
      err = 1'b1;
    end else begin
      st_o.slots  = s_dep;
      st_o.served = sv_dep;
      if (dep_enter) begin
        st_o.waiters[cls] = w_cls - tcpa_pkg::WaitW'(1);
        st_o.slots        = st_i.slots;
        gcls = cls;
        gcnt = tcpa_pkg::SlotW'(1);
      end else if (dep_switch) begin
        st_o.phase        = oth;
        st_o.served       = '0;
        st_o.slots        = batch;
        st_o.waiters[oth] = w_oth - tcpa_pkg::WaitW'(batch);
        gcls = oth;
        gcnt = batch;
      end
    end
  end

  always_comb begin
    res_o.grant_class  = gcls;
    res_o.grant_count  = gcnt;
    res_o.phase        = st_o.phase;
    res_o.occupancy    = st_o.slots;
    res_o.waiting_zero = st_o.waiters[0];
    res_o.waiting_one  = st_o.waiters[1];
    res_o.error        = err;
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // Shadow of the arbiter: tracks phase, waiters, served count and occupied slots,
  // and holds the results that accepted events must produce, oldest first.
  class admission_scoreboard;
    logic                         phase;
    logic [tcpa_pkg::WaitW-1:0]   waiters [tcpa_pkg::NumCls];
    logic [tcpa_pkg::ServedW-1:0] served;
    logic [tcpa_pkg::SlotW-1:0]   slots;
    logic [tcpa_pkg::SlotW-1:0]   num_slots;
    logic [tcpa_pkg::ThreshW-1:0] switch_thr;
    tcpa_pkg::res_t               expected_grants [$];
    int unsigned                  mismatches;

    function new();
      phase      = 1'b0;
      waiters[0] = '0;
      waiters[1] = '0;
      served     = '0;
      slots      = '0;
      num_slots  = 5'd4;
      switch_thr = 8'd8;
      mismatches = 0;
    endfunction

    function int unsigned slot_cap();
      if (num_slots == '0) return 1;
      if (num_slots > tcpa_pkg::MaxSlots) return tcpa_pkg::MaxSlots;
      return {27'd0, num_slots};
    endfunction

    function int unsigned quota_used();
      return {27'd0, slots} + {24'd0, served};
    endfunction

    function int unsigned backlog();
      return {27'd0, slots} + {24'd0, waiters[0]} + {24'd0, waiters[1]};
    endfunction

    function bit can_join(logic c);
      logic o;
      o = ~c;
      return phase == c && waiters[c] != '0 && slots < slot_cap() &&
             (quota_used() < switch_thr || waiters[o] == '0);
    endfunction

    function bit can_take_over(logic c);
      logic o;
      o = ~c;
      return phase != c && slots == '0 && waiters[c] != '0 &&
             (quota_used() >= switch_thr || waiters[o] == '0);
    endfunction

    function void set_register(tcpa_pkg::cfg_idx_e idx, logic [tcpa_pkg::CfgW-1:0] data);
      case (idx)
        tcpa_pkg::CfgNumSlots: begin
          num_slots = data[tcpa_pkg::SlotW-1:0];
        end
        tcpa_pkg::CfgSwitchThr: begin
          switch_thr = data[tcpa_pkg::ThreshW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function tcpa_pkg::res_t admit_event(tcpa_pkg::evt_t e);
      tcpa_pkg::res_t r;
      logic           c;
      logic           o;
      int unsigned    n;
      c = e.req_class;
      o = ~c;
      r = '0;
      if (e.mode == tcpa_pkg::ModeArrive) begin
        if (waiters[c] == tcpa_pkg::WaitMax) r.error = 1'b1;
        else waiters[c]++;
        if (can_join(c) || can_take_over(c)) begin
          if (phase != c) begin
            phase  = c;
            served = '0;
          end
          waiters[c]--;
          slots++;
          r.grant_class = c;
          r.grant_count = tcpa_pkg::SlotW'(1);
        end
      end else if (slots == '0) begin
        r.error = 1'b1;
      end else begin
        // The departing class does not have to match the phase; any departure frees a slot.
        slots--;
        if (served != tcpa_pkg::ServedMax) served++;
        if (can_join(c)) begin
          waiters[c]--;
          slots++;
          r.grant_class = c;
          r.grant_count = tcpa_pkg::SlotW'(1);
        end else if (can_take_over(o)) begin
          n      = slot_cap();
          phase  = o;
          served = '0;
          if ({24'd0, waiters[o]} < n) n = {24'd0, waiters[o]};
          slots      = tcpa_pkg::SlotW'(n);
          waiters[o] = waiters[o] - tcpa_pkg::WaitW'(n);
          r.grant_class = o;
          r.grant_count = tcpa_pkg::SlotW'(n);
        end
      end
      r.phase        = phase;
      r.occupancy    = slots;
      r.waiting_zero = waiters[0];
      r.waiting_one  = waiters[1];
      return r;
    endfunction

    function void note_event(tcpa_pkg::evt_t e);
      expected_grants.push_back(admit_event(e));
    endfunction

    // Next event that walks the pool back to empty with no waiters left.
    // Departures of the phase class admit a waiter when the last slot frees, if any waiter is left;
    // with an empty pool but waiters left, an arrival of a class that can get in restarts it.
    function tcpa_pkg::evt_t unwind_step();
      tcpa_pkg::evt_t e;
      logic           o;
      o = ~phase;
      if (slots != '0) e = '{mode: tcpa_pkg::ModeDepart, req_class: phase};
      else if (waiters[phase] != '0 && quota_used() < switch_thr)
        e = '{mode: tcpa_pkg::ModeArrive, req_class: phase};
      else e = '{mode: tcpa_pkg::ModeArrive, req_class: o};
      return e;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [tcpa_pkg::WaitW-1:0] got,
                       logic [tcpa_pkg::WaitW-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_grant(tcpa_pkg::res_t got);
      tcpa_pkg::res_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch("result transfer with no event outstanding");
      end else begin
        want = expected_grants.pop_front();
        compare_field("grant_class", tcpa_pkg::WaitW'(got.grant_class),
                      tcpa_pkg::WaitW'(want.grant_class));
        compare_field("grant_count", tcpa_pkg::WaitW'(got.grant_count),
                      tcpa_pkg::WaitW'(want.grant_count));
        compare_field("phase", tcpa_pkg::WaitW'(got.phase), tcpa_pkg::WaitW'(want.phase));
        compare_field("occupancy", tcpa_pkg::WaitW'(got.occupancy),
                      tcpa_pkg::WaitW'(want.occupancy));
        compare_field("waiting_zero", got.waiting_zero, want.waiting_zero);
        compare_field("waiting_one", got.waiting_one, want.waiting_one);
        compare_field("error", tcpa_pkg::WaitW'(got.error), tcpa_pkg::WaitW'(want.error));
      end
    endtask
  endclass

  localparam int unsigned NumPhases   = 10;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [tcpa_pkg::CfgW-1:0] SlotSettings [NumPhases] =
    '{8'd4, 8'd1, 8'd16, 8'd0, 8'd31, 8'hE5, 8'd2, 8'd16, 8'd7, 8'd3};
  localparam logic [tcpa_pkg::CfgW-1:0] ThrSettings [NumPhases] =
    '{8'd8, 8'd1, 8'd255, 8'd0, 8'd3, 8'd200, 8'd2, 8'd1, 8'd255, 8'd0};

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  tcpa_pkg::cfg_idx_e        cfg_idx;
  logic [tcpa_pkg::CfgW-1:0] cfg_data;

  bit sink_gaps;
  bit hold_results;

  admission_scoreboard sb = new();

  tcpa_stream_if #(.payload_t(tcpa_pkg::evt_t)) evt_if ();
  tcpa_stream_if #(.payload_t(tcpa_pkg::res_t)) res_if ();

  two_class_phase_admission_arbiter u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_register(cfg_idx, cfg_data);
      if (evt_if.valid && evt_if.ready) sb.note_event(evt_if.payload);
      if (res_if.valid && res_if.ready) sb.check_grant(res_if.payload);
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_results = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_event(tcpa_pkg::mode_e m, logic c);
    evt_if.valid   <= 1'b1;
    evt_if.payload <= '{mode: m, req_class: c};
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
  endtask

  task automatic idle_source(int unsigned cycles);
    evt_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding result has been checked.
  task automatic drain();
    evt_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_grants.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(logic [tcpa_pkg::CfgW-1:0] slots_val,
                                logic [tcpa_pkg::CfgW-1:0] thr_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= tcpa_pkg::CfgNumSlots;
    cfg_data <= slots_val;
    @(posedge clk);
    cfg_idx  <= tcpa_pkg::CfgSwitchThr;
    cfg_data <= thr_val;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // The source goes idle after each transfer so the shadow state settles before the next pick.
  task automatic unwind_pool();
    tcpa_pkg::evt_t e;
    drain();
    while (sb.backlog() != 0) begin
      e = sb.unwind_step();
      push_event(tcpa_pkg::mode_e'(e.mode), e.req_class);
      idle_source(1);
    end
    drain();
  endtask

  // Two slots held by class c while its waiter count runs into saturation; a departure of
  // the other class then frees a slot so a saturated arrival is still admitted.
  task automatic saturate_waiters(logic c);
    unwind_pool();
    write_settings(8'd2, 8'd255);
    repeat (tcpa_pkg::MaxWaiters + 5) push_event(tcpa_pkg::ModeArrive, c);
    push_event(tcpa_pkg::ModeDepart, ~c);
    push_event(tcpa_pkg::ModeArrive, c);
    unwind_pool();
  endtask

  task automatic run_traffic(int unsigned count, bit gaps);
    int unsigned     depart_pct;
    int unsigned     one_pct;
    int unsigned     run_len;
    int unsigned     done;
    tcpa_pkg::mode_e m;
    logic            c;
    depart_pct = $urandom_range(25, 55);
    one_pct    = $urandom_range(10, 90);
    done       = 0;
    while (done < count) begin
      run_len = $urandom_range(1, 12);
      m = ($urandom_range(0, 99) < depart_pct) ? tcpa_pkg::ModeDepart : tcpa_pkg::ModeArrive;
      c = ($urandom_range(0, 99) < one_pct);
      repeat (run_len) begin
        if (gaps && $urandom_range(0, 4) == 0) idle_source($urandom_range(1, 7));
        if ($urandom_range(0, 9) == 0)
          push_event(tcpa_pkg::mode_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          push_event(m, c);
        done++;
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= tcpa_pkg::CfgNumSlots;
    cfg_data       <= '0;
    evt_if.valid   <= 1'b0;
    evt_if.payload <= '0;
    sink_gaps    = 1'b1;
    hold_results = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short walk through the reset settings: empty-pool departures, an arrival that takes
    // over the phase, a full pool, a departure of the class out of phase, and a phase switch.
    push_event(tcpa_pkg::ModeDepart, 1'b0);
    push_event(tcpa_pkg::ModeDepart, 1'b1);
    repeat (5) push_event(tcpa_pkg::ModeArrive, 1'b1);
    repeat (2) push_event(tcpa_pkg::ModeArrive, 1'b0);
    push_event(tcpa_pkg::ModeDepart, 1'b0);
    repeat (4) push_event(tcpa_pkg::ModeDepart, 1'b1);
    repeat (3) push_event(tcpa_pkg::ModeArrive, 1'b1);
    repeat (2) push_event(tcpa_pkg::ModeArrive, 1'b0);
    repeat (3) push_event(tcpa_pkg::ModeDepart, 1'b0);
    drain();

    saturate_waiters(1'b0);
    saturate_waiters(1'b1);

    for (int i = 0; i < NumPhases; i++) begin
      write_settings(SlotSettings[i], ThrSettings[i]);
      sink_gaps = ($urandom_range(0, 2) != 0);
      if (i == 2) hold_results = 1'b1;
      run_traffic($urandom_range(40, 80), $urandom_range(0, 2) != 0);
      drain();
    end

    sink_gaps = 1'b0;
    write_settings(tcpa_pkg::CfgW'($urandom_range(1, tcpa_pkg::MaxSlots)),
                   tcpa_pkg::CfgW'($urandom_range(1, 255)));
    run_traffic(200, 1'b0);
    drain();

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
